// ----- sv/twcw_pkg.sv -----
// twcw_pkg: shared types, codes and constants of the text window cell writer.
// No dependencies; the sequencer, the top level and the bench import it.
package twcw_pkg;

  localparam int COL_W     = 7;   // cursor column / width register
  localparam int ROW_W     = 5;   // cursor row / height register
  localparam int CHR_W     = 8;
  localparam int CLR_W     = 6;
  localparam int IDX_W     = 13;  // linear cell index, covers any row * col + col
  localparam int CFG_W     = 7;   // widest register
  localparam int CFG_IDX_W = 3;

  localparam int MAX_COLS_DEF = 80;
  localparam int MAX_ROWS_DEF = 30;
  localparam int TAB_STOP_DEF = 8;

  // register reset values
  localparam logic [COL_W-1:0] WIDTH_RST  = 7'd80;
  localparam logic [ROW_W-1:0] HEIGHT_RST = 5'd30;
  localparam logic [CLR_W-1:0] FORE_RST   = 6'd63;
  localparam logic [CLR_W-1:0] BACK_RST   = 6'd0;
  localparam logic             BOLD_RST   = 1'b0;
  localparam logic             REV_RST    = 1'b0;
  localparam logic             SCROLL_RST = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOLD    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL  = 3'd6;

  // command codes
  localparam logic [2:0] CMD_PUT    = 3'd0;
  localparam logic [2:0] CMD_MOVE   = 3'd1;
  localparam logic [2:0] CMD_CLEAR  = 3'd2;
  localparam logic [2:0] CMD_EOL    = 3'd3;
  localparam logic [2:0] CMD_BOTTOM = 3'd4;
  localparam logic [2:0] CMD_READ   = 3'd5;

  // control characters
  localparam logic [CHR_W-1:0] CH_BS  = 8'd8;
  localparam logic [CHR_W-1:0] CH_TAB = 8'd9;
  localparam logic [CHR_W-1:0] CH_LF  = 8'd10;
  localparam logic [CHR_W-1:0] CH_CR  = 8'd13;

  typedef struct packed {
    logic [CLR_W-1:0] back;
    logic [CLR_W-1:0] fore;
    logic             bold;
    logic [CHR_W-1:0] chr;
  } cell_t;

  localparam int CELL_W = $bits(cell_t);

  typedef struct packed {
    logic [2:0]              command;
    logic [CHR_W-1:0]        character;
    logic signed [CHR_W-1:0] row;
    logic signed [CHR_W-1:0] col;
  } cmd_t;

  typedef struct packed {
    logic [ROW_W-1:0] cursor_row;
    logic [COL_W-1:0] cursor_col;
    logic [CHR_W-1:0] cell_char;
    logic             cell_bold;
    logic [CLR_W-1:0] cell_fore;
    logic [CLR_W-1:0] cell_back;
    logic             scrolled;
  } rsp_t;

  // window settings as the sequencer sees them (sizes already saturated,
  // colours already swapped for reverse)
  typedef struct packed {
    logic [COL_W-1:0] w;
    logic [ROW_W-1:0] h;
    logic [IDX_W-1:0] area;
    logic [CLR_W-1:0] fore;
    logic [CLR_W-1:0] back;
    logic             bold;
    logic             scroll;
  } cfg_t;

  // cell memory access request
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    cell_t            wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

// ----- sv/twcw_ram.sv -----
// twcw_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies. Read during write of the same entry returns the old data.
module twcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
    rdata <= store[raddr];
  end

endmodule

// ----- sv/twcw_seq.sv -----
// twcw_seq: command sequencer; owns the cursor and drives the cell memory.
// Depends on twcw_pkg. Cells sit row-major with stride equal to the width in use.
module twcw_seq import twcw_pkg::*; #(
  parameter int TAB_STOP = TAB_STOP_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     start,
  input  cmd_t     item,
  output logic     idle,
  input  logic     slot_free,
  output logic     post,
  output rsp_t     result,
  output mem_req_t mem,
  input  cell_t    rdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_RWAIT = 3'd2;
  localparam logic [2:0] S_SCR   = 3'd3;
  localparam logic [2:0] S_FILL  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam int TAB_N = 2**COL_W;

  logic [2:0]             state, state_next;
  logic [2:0]             op;
  logic [CHR_W-1:0]       chr;
  logic [ROW_W-1:0]       row_cl, row_in_cl, cy_cl, cursor_y, cursor_y_next, mul_row, h_m1;
  logic [COL_W-1:0]       col_cl, col_in_cl, cx_cl, cursor_x, cursor_x_next, w_m1;
  logic [ROW_W+COL_W-1:0] prod;
  logic [IDX_W-1:0]       base, cell_idx, ptr, fend, rptr, wptr;
  logic                   rd_pend, scrolled, res_rd;
  cell_t                  res_cell, blank, put_cell;
  logic [CHR_W-1:0]       tab_tbl [TAB_N];
  logic [CHR_W-1:0]       tab_pos;
  logic                   nl, go_scroll;

  // next tab stop for every column
  for (genvar gx = 0; gx < TAB_N; gx++) begin : g_tab
    assign tab_tbl[gx] = CHR_W'((gx / TAB_STOP + 1) * TAB_STOP);
  end

  assign h_m1    = cfg.h - 1'b1;
  assign w_m1    = cfg.w - 1'b1;
  assign tab_pos = tab_tbl[cursor_x];

  // clamp the requested position and the stored cursor into the window
  always_comb begin
    if (item.row[CHR_W-1]) begin
      row_in_cl = '0;
    end else if (item.row[CHR_W-2:0] >= {2'b00, cfg.h}) begin
      row_in_cl = h_m1;
    end else begin
      row_in_cl = item.row[ROW_W-1:0];
    end
    if (item.col[CHR_W-1]) begin
      col_in_cl = '0;
    end else if (item.col[CHR_W-2:0] >= cfg.w) begin
      col_in_cl = w_m1;
    end else begin
      col_in_cl = item.col[COL_W-1:0];
    end
    cy_cl   = (cursor_y > h_m1) ? h_m1 : cursor_y;
    cx_cl   = (cursor_x > w_m1) ? w_m1 : cursor_x;
    mul_row = (item.command == CMD_READ) ? row_in_cl : cy_cl;
    prod    = mul_row * cfg.w;
  end

  assign blank    = '{back: cfg.back, fore: cfg.fore, bold: 1'b0, chr: '0};
  assign put_cell = '{back: cfg.back, fore: cfg.fore, bold: cfg.bold, chr: chr};
  assign cell_idx = base + IDX_W'(cursor_x);

  always_comb begin
    state_next    = state;
    cursor_y_next = cursor_y;
    cursor_x_next = cursor_x;
    nl            = 1'b0;
    go_scroll     = 1'b0;
    post          = 1'b0;
    mem.we        = 1'b0;
    mem.waddr     = ptr;
    mem.wdata     = blank;
    mem.raddr     = rptr;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (op)
          CMD_PUT: begin
            if (chr == CH_BS) begin
              if (cursor_x != '0) begin
                cursor_x_next = cursor_x - 1'b1;
              end else if (cursor_y != '0) begin
                cursor_y_next = cursor_y - 1'b1;
                cursor_x_next = w_m1;
              end
            end else if (chr == CH_LF) begin
              cursor_x_next = '0;
              nl            = 1'b1;
            end else if (chr == CH_CR) begin
              cursor_x_next = '0;
            end else if (chr == CH_TAB) begin
              if (tab_pos >= {1'b0, cfg.w}) begin
                cursor_x_next = '0;
                nl            = 1'b1;
              end else begin
                cursor_x_next = tab_pos[COL_W-1:0];
              end
            end else begin
              mem.we    = 1'b1;
              mem.waddr = cell_idx;
              mem.wdata = put_cell;
              if (cursor_x == w_m1) begin
                cursor_x_next = '0;
                nl            = 1'b1;
              end else begin
                cursor_x_next = cursor_x + 1'b1;
              end
            end
            if (nl) begin
              if (cursor_y == h_m1) begin
                if (cfg.scroll) begin
                  go_scroll = 1'b1;
                end else begin
                  cursor_y_next = '0;
                end
              end else begin
                cursor_y_next = cursor_y + 1'b1;
              end
            end
          end
          CMD_MOVE: begin
            cursor_y_next = row_cl;
            cursor_x_next = col_cl;
          end
          CMD_READ: begin
            mem.raddr = base + IDX_W'(col_cl);
          end
          default: begin
          end
        endcase
        if (op == CMD_CLEAR || op == CMD_EOL || op == CMD_BOTTOM) begin
          state_next = S_FILL;
        end else if (op == CMD_READ) begin
          state_next = S_RWAIT;
        end else if (go_scroll) begin
          state_next = S_SCR;
        end else if (slot_free) begin
          post       = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_RWAIT: begin
        state_next = S_DONE;
      end
      S_SCR: begin
        // read each cell of row r+1 and write it back to row r once the registered read returns
        mem.raddr = rptr;
        if (rd_pend) begin
          mem.we    = 1'b1;
          mem.waddr = wptr;
          mem.wdata = rdata;
        end
        if (rptr >= cfg.area && !rd_pend) begin
          state_next = S_FILL;
        end
      end
      S_FILL: begin
        mem.we = 1'b1;
        if (ptr + 1'b1 >= fend) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          post       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cursor_y <= '0;
      cursor_x <= '0;
      rd_pend  <= 1'b0;
      scrolled <= 1'b0;
      res_rd   <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (start) begin
            cursor_y <= cy_cl;
            cursor_x <= cx_cl;
            scrolled <= 1'b0;
            res_rd   <= 1'b0;
          end
        end
        S_EXEC: begin
          cursor_y <= cursor_y_next;
          cursor_x <= cursor_x_next;
          if (go_scroll) begin
            rd_pend  <= 1'b0;
            scrolled <= 1'b1;
          end
        end
        S_RWAIT: begin
          res_rd <= 1'b1;
        end
        S_SCR: begin
          rd_pend <= (rptr < cfg.area);
        end
        default: begin
        end
      endcase
    end
  end

  // item and pointer registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          op     <= item.command;
          chr    <= item.character;
          row_cl <= row_in_cl;
          col_cl <= col_in_cl;
          base   <= IDX_W'(prod);
        end
      end
      S_EXEC: begin
        case (op)
          CMD_CLEAR: begin
            ptr  <= '0;
            fend <= cfg.area;
          end
          CMD_EOL: begin
            ptr  <= cell_idx;
            fend <= base + IDX_W'(cfg.w);
          end
          CMD_BOTTOM: begin
            ptr  <= cell_idx;
            fend <= cfg.area;
          end
          default: begin
          end
        endcase
        if (go_scroll) begin
          rptr <= IDX_W'(cfg.w);
          wptr <= '0;
        end
      end
      S_RWAIT: begin
        res_cell <= rdata;
      end
      S_SCR: begin
        if (rd_pend) begin
          wptr <= wptr + 1'b1;
        end
        if (rptr < cfg.area) begin
          rptr <= rptr + 1'b1;
        end else if (!rd_pend) begin
          // copy done: blank the freed bottom row
          ptr  <= wptr;
          fend <= cfg.area;
        end
      end
      S_FILL: begin
        ptr <= ptr + 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign idle = (state == S_IDLE);

  always_comb begin
    result.cursor_row = cursor_y_next;
    result.cursor_col = cursor_x_next;
    result.cell_char  = res_rd ? res_cell.chr  : '0;
    result.cell_bold  = res_rd ? res_cell.bold : 1'b0;
    result.cell_fore  = res_rd ? res_cell.fore : '0;
    result.cell_back  = res_rd ? res_cell.back : '0;
    result.scrolled   = scrolled;
  end

endmodule

// ----- sv/text_window_cell_writer.sv -----
// text_window_cell_writer: top level; configuration registers, result register,
// cell memory (twcw_ram) and command sequencer (twcw_seq). Depends on twcw_pkg.
//
// Runs one command per cmd beat and returns exactly one rsp beat for it. Commands
// are handled one at a time: cmd_ready is high only while the sequencer is idle.
// Read cell adds a memory read plus capture; a clear of N cells writes them in
// turn through the single write port of the cell memory; a scroll moves w*(h-1)
// cells at one per cycle and then blanks the bottom row. The next cmd beat is
// taken as soon as the result has been placed in the output register, even if
// that beat is not yet taken downstream. The cell memory has no reset and no
// clearing pass: a cell that was never written reads as garbage. Write
// registers only while no command is in flight.
module text_window_cell_writer import twcw_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int TAB_STOP = TAB_STOP_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  cmd_t                 cmd,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output rsp_t                 rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration registers
  logic [COL_W-1:0] win_width;
  logic [ROW_W-1:0] win_height;
  logic [CLR_W-1:0] fore_colour;
  logic [CLR_W-1:0] back_colour;
  logic             bold_on;
  logic             reverse_on;
  logic             scroll_enable;

  logic [COL_W-1:0] w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [IDX_W-1:0] area;
  cfg_t             cfg;
  logic             start, idle, slot_free, post;
  rsp_t             result;
  mem_req_t         mem;
  cell_t            ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_width     <= WIDTH_RST;
      win_height    <= HEIGHT_RST;
      fore_colour   <= FORE_RST;
      back_colour   <= BACK_RST;
      bold_on       <= BOLD_RST;
      reverse_on    <= REV_RST;
      scroll_enable <= SCROLL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:   win_width     <= cfg_data[COL_W-1:0];
        CFG_HEIGHT:  win_height    <= cfg_data[ROW_W-1:0];
        CFG_FORE:    fore_colour   <= cfg_data[CLR_W-1:0];
        CFG_BACK:    back_colour   <= cfg_data[CLR_W-1:0];
        CFG_BOLD:    bold_on       <= cfg_data[0];
        CFG_REVERSE: reverse_on    <= cfg_data[0];
        CFG_SCROLL:  scroll_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // sizes saturate into 1..MAX
  always_comb begin
    if (win_width == '0) begin
      w_eff = COL_W'(1);
    end else if (int'(win_width) > MAX_COLS) begin
      w_eff = COL_W'(MAX_COLS);
    end else begin
      w_eff = win_width;
    end
    if (win_height == '0) begin
      h_eff = ROW_W'(1);
    end else if (int'(win_height) > MAX_ROWS) begin
      h_eff = ROW_W'(MAX_ROWS);
    end else begin
      h_eff = win_height;
    end
  end

  // window cell count, registered off the config path
  always_ff @(posedge clk) begin
    area <= IDX_W'(w_eff) * IDX_W'(h_eff);
  end

  always_comb begin
    cfg.w      = w_eff;
    cfg.h      = h_eff;
    cfg.area   = area;
    cfg.fore   = reverse_on ? back_colour : fore_colour;
    cfg.back   = reverse_on ? fore_colour : back_colour;
    cfg.bold   = bold_on;
    cfg.scroll = scroll_enable;
  end

  assign cmd_ready = idle;
  assign start     = cmd_valid && cmd_ready;
  assign slot_free = !rsp_valid || rsp_ready;

  twcw_seq #(
    .TAB_STOP (TAB_STOP)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (start),
    .item      (cmd),
    .idle      (idle),
    .slot_free (slot_free),
    .post      (post),
    .result    (result),
    .mem       (mem),
    .rdata     (ram_rdata)
  );

  twcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem.we),
    .waddr (AW'(mem.waddr)),
    .wdata (mem.wdata),
    .raddr (AW'(mem.raddr)),
    .rdata (ram_rdata)
  );

  // output register: a finished result waits here while the next beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (post) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (post) begin
      rsp <= result;
    end
  end

  // one command in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("cmd beat accepted while sequencer busy");

  // a result is only posted into a free or draining output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    post |-> slot_free)
    else $error("result posted over a waiting rsp beat");

  // cell writes stay inside the memory
  a_waddr_range: assert property (@(posedge clk) disable iff (rst)
    mem.we |-> {1'b0, mem.waddr} < (IDX_W+1)'(DEPTH))
    else $error("cell write beyond memory depth");

endmodule

// ----- test/tb.sv -----
// tb: self-checking bench for text_window_cell_writer, the character-cell text window.
// Needs twcw_pkg and the block's RTL; an in-bench predictor supplies expected reply beats.
`timescale 1ns / 100ps

module tb;
  import twcw_pkg::*;

  // Unused command codes: the block must leave everything alone and report the cursor.
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  localparam int CELLS      = MAX_COLS_DEF * MAX_ROWS_DEF;
  // Watchdog limit on quiet cycles; the slowest command is a full-window
  // scroll or clear, plus a short receiver stall.
  localparam int HANG_LIMIT = 10000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 cmd_valid = 1'b0;
  logic                 cmd_ready;
  cmd_t                 cmd       = '0;
  logic                 rsp_valid;
  logic                 rsp_ready = 1'b0;
  rsp_t                 rsp;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  always #4 clk = ~clk;

  text_window_cell_writer i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the cell store, cursor and registers.
  // The store is linear; cell (r, c) lives at r * width + c, so a width change
  // reinterprets what is already there, exactly as the block does.
  // ---------------------------------------------------------------------------
  cell_t            screen [CELLS];
  int               cur_y;
  int               cur_x;
  logic [COL_W-1:0] reg_width;
  logic [ROW_W-1:0] reg_height;
  logic [CLR_W-1:0] reg_fore;
  logic [CLR_W-1:0] reg_back;
  logic             reg_bold;
  logic             reg_rev;
  logic             reg_scroll;

  rsp_t replies_due [$];   // predicted reply beats, oldest first
  rsp_t due;
  int   errors = 0;
  int   quiet  = 0;        // cycles without any beat or register write
  bit   idle_on = 1'b1;    // random gaps on both channels
  int   stall_left = 0;

  // Sizes saturate: 0 counts as 1, anything past the maximum as the maximum.
  function automatic int cols_in_use();
    return (reg_width == 0) ? 1 : (reg_width > MAX_COLS_DEF) ? MAX_COLS_DEF : reg_width;
  endfunction

  function automatic int rows_in_use();
    return (reg_height == 0) ? 1 : (reg_height > MAX_ROWS_DEF) ? MAX_ROWS_DEF : reg_height;
  endfunction

  // Cell with the current colours, swapped under reverse video.
  function automatic cell_t paint(logic [CHR_W-1:0] ch, logic bold);
    cell_t c;
    c.chr  = ch;
    c.bold = bold;
    c.fore = reg_rev ? reg_back : reg_fore;
    c.back = reg_rev ? reg_fore : reg_back;
    return c;
  endfunction

  function automatic void blank_span(int from, int to);
    for (int i = from; i < to && i < CELLS; i++) screen[i] = paint('0, 1'b0);
  endfunction

  // Signed row/col operand clamped into 0..lim-1.
  function automatic int clamp_pos(logic signed [CHR_W-1:0] v, int lim);
    if (v < 0) return 0;
    if (int'(v) > lim - 1) return lim - 1;
    return int'(v);
  endfunction

  // Runs one command against the predictor state and returns the reply it owes.
  function automatic rsp_t next_reply(cmd_t c);
    int    w;
    int    h;
    int    n;
    bit    wrap;
    cell_t got;
    rsp_t  o;
    w    = cols_in_use();
    h    = rows_in_use();
    wrap = 1'b0;
    o    = '0;
    // a shrunk window pulls the cursor back in before anything else
    if (cur_y > h - 1) cur_y = h - 1;
    if (cur_x > w - 1) cur_x = w - 1;
    case (c.command)
      CMD_PUT: begin
        if (c.character == CH_BS) begin
          if (cur_x != 0) begin
            cur_x--;
          end else if (cur_y != 0) begin
            cur_y--;
            cur_x = w - 1;
          end
        end else if (c.character == CH_LF) begin
          cur_x = 0;
          wrap  = 1'b1;
        end else if (c.character == CH_CR) begin
          cur_x = 0;
        end else if (c.character == CH_TAB) begin
          cur_x = (1 + cur_x / TAB_STOP_DEF) * TAB_STOP_DEF;
          if (cur_x >= w) begin
            cur_x = 0;
            wrap  = 1'b1;
          end
        end else begin
          screen[cur_y * w + cur_x] = paint(c.character, reg_bold);
          if (cur_x == w - 1) begin
            cur_x = 0;
            wrap  = 1'b1;
          end else begin
            cur_x++;
          end
        end
        if (wrap) begin
          if (cur_y == h - 1) begin
            if (reg_scroll) begin
              // shift rows up by one and blank the bottom row
              n = w * (h - 1);
              for (int k = 0; k < n; k++) screen[k] = screen[k + w];
              blank_span(n, n + w);
              o.scrolled = 1'b1;
            end else begin
              cur_y = 0;
            end
          end else begin
            cur_y++;
          end
        end
      end
      CMD_MOVE: begin
        cur_y = clamp_pos(c.row, h);
        cur_x = clamp_pos(c.col, w);
      end
      CMD_CLEAR:  blank_span(0, w * h);
      CMD_EOL:    blank_span(cur_y * w + cur_x, cur_y * w + w);
      CMD_BOTTOM: blank_span(cur_y * w + cur_x, w * h);
      CMD_READ: begin
        // read position is clamped; cursor stays put
        got         = screen[clamp_pos(c.row, h) * w + clamp_pos(c.col, w)];
        o.cell_char = got.chr;
        o.cell_bold = got.bold;
        o.cell_fore = got.fore;
        o.cell_back = got.back;
      end
      default: ;
    endcase
    o.cursor_row = cur_y;
    o.cursor_col = cur_x;
    return o;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predicts on each cmd beat, checks each rsp beat, and runs the
  // hang watchdog. Everything sampled here is the pre-edge value.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      quiet <= 0;
    end else begin
      if (cmd_valid && cmd_ready) replies_due.push_back(next_reply(cmd));
      if (rsp_valid && rsp_ready) begin
        if (replies_due.size() == 0) begin
          $error("reply beat with no command outstanding");
          errors++;
        end else begin
          due = replies_due.pop_front();
          check_field("cursor_row", due.cursor_row, rsp.cursor_row);
          check_field("cursor_col", due.cursor_col, rsp.cursor_col);
          check_field("cell_char",  due.cell_char,  rsp.cell_char);
          check_field("cell_bold",  due.cell_bold,  rsp.cell_bold);
          check_field("cell_fore",  due.cell_fore,  rsp.cell_fore);
          check_field("cell_back",  due.cell_back,  rsp.cell_back);
          check_field("scrolled",   due.scrolled,   rsp.scrolled);
        end
      end
      if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready) || cfg_we) begin
        quiet <= 0;
      end else if (quiet >= HANG_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // Receiver back-pressure: random stall bursts while idling is on.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      rsp_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      rsp_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // One cmd beat. Valid is only dropped when a gap is taken, so back-to-back
  // beats keep it high with a single assignment per edge.
  task automatic send_cmd(input cmd_t c);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    do @(posedge clk); while (!cmd_ready);
  endtask

  // Hold off until every reply is back; the block is idle after that.
  task automatic drain_replies();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_WIDTH:   reg_width  = val;
      CFG_HEIGHT:  reg_height = val;
      CFG_FORE:    reg_fore   = val;
      CFG_BACK:    reg_back   = val;
      CFG_BOLD:    reg_bold   = val;
      CFG_REVERSE: reg_rev    = val;
      CFG_SCROLL:  reg_scroll = val;
      default: ;
    endcase
  endtask

  task automatic set_window(input int w, input int h, input int fg, input int bg,
                            input int bold, input int rev, input int scroll);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_FORE, fg);
    write_reg(CFG_BACK, bg);
    write_reg(CFG_BOLD, bold);
    write_reg(CFG_REVERSE, rev);
    write_reg(CFG_SCROLL, scroll);
  endtask

  function automatic cmd_t beat(logic [2:0] op, int ch, int r, int c);
    cmd_t b;
    b.command   = op;
    b.character = ch;
    b.row       = r;
    b.col       = c;
    return b;
  endfunction

  // Half the time a position inside the window, else any signed byte.
  function automatic logic [CHR_W-1:0] aim(int lim);
    return $urandom_range(0, 1) ? $urandom_range(0, lim - 1) : $urandom_range(0, 255);
  endfunction

  // Random command mix. Full-window clears are long, so they are thinned out
  // on big windows; clear-to-eol is cheap and always allowed.
  function automatic cmd_t pick_cmd();
    cmd_t c;
    int   roll;
    int   w;
    int   h;
    w           = cols_in_use();
    h           = rows_in_use();
    c.command   = CMD_PUT;
    c.character = $urandom_range(0, 255);
    c.row       = $urandom_range(0, 255);
    c.col       = $urandom_range(0, 255);
    roll        = $urandom_range(0, 99);
    if (roll < 50) begin
      // plain character (control codes show up here now and then too)
    end else if (roll < 66) begin
      case ($urandom_range(0, 3))
        0:       c.character = CH_BS;
        1:       c.character = CH_TAB;
        2:       c.character = CH_LF;
        default: c.character = CH_CR;
      endcase
    end else if (roll < 88) begin
      c.command = (roll < 76) ? CMD_MOVE : CMD_READ;
      c.row     = aim(h);
      c.col     = aim(w);
    end else if (roll < 90) begin
      c.command = $urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI;
    end else if (roll < 95) begin
      c.command = CMD_EOL;
    end else if (w * h <= 256 || $urandom_range(0, 7) == 0) begin
      c.command = $urandom_range(0, 1) ? CMD_CLEAR : CMD_BOTTOM;
    end
    return c;
  endfunction

  task automatic run_items(input int n);
    repeat (n) send_cmd(pick_cmd());
    drain_replies();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset window (80 x 30). The opening clear writes every entry of the store,
  // so no later read, under any window size, can land on a never-written cell.
  task automatic test_directed();
    send_cmd(beat(CMD_CLEAR, 0, 0, 0));
    send_cmd(beat(CMD_PUT, 8'h41, 0, 0));
    send_cmd(beat(CMD_READ, 0, 0, 0));
    send_cmd(beat(CMD_PUT, CH_BS, 0, 0));
    send_cmd(beat(CMD_PUT, CH_BS, 0, 0));       // backspace at origin: no change
    send_cmd(beat(CMD_PUT, CH_TAB, 0, 0));
    send_cmd(beat(CMD_MOVE, 0, 0, 75));
    send_cmd(beat(CMD_PUT, CH_TAB, 0, 0));      // tab past row end: next line
    send_cmd(beat(CMD_PUT, 255, -1, -1));
    send_cmd(beat(CMD_PUT, CH_CR, 0, 0));
    send_cmd(beat(CMD_PUT, CH_LF, 0, 0));
    send_cmd(beat(CMD_MOVE, 0, -128, -128));
    send_cmd(beat(CMD_MOVE, 0, 127, 127));      // clamps to bottom-right
    send_cmd(beat(CMD_PUT, 8'h5a, 0, 0));       // wrap on the last row: scroll
    send_cmd(beat(CMD_READ, 0, 28, 79));
    send_cmd(beat(CMD_READ, 0, 127, -128));     // fresh blank row
    send_cmd(beat(CMD_PUT, CH_BS, 0, 0));       // back onto the previous row end
    send_cmd(beat(CMD_MOVE, 0, 28, 40));
    send_cmd(beat(CMD_EOL, 0, 0, 0));
    send_cmd(beat(CMD_READ, 0, 28, 79));
    send_cmd(beat(CMD_MOVE, 0, 0, 3));
    send_cmd(beat(CMD_BOTTOM, 0, 0, 0));
    send_cmd(beat(CMD_SPARE_LO, 8'h41, 5, 5));
    send_cmd(beat(CMD_SPARE_HI, 8'hbe, -5, 5));
    send_cmd(beat(CMD_READ, 0, 0, 2));
    drain_replies();
  endtask

  // Size extremes, out-of-range sizes, colour extremes, every flag both ways.
  task automatic test_extreme_sizes();
    set_window(1, 1, 0, 63, 1, 1, 1);
    run_items(80);
    set_window(0, 0, 63, 0, 0, 0, 0);           // zero sizes count as one
    run_items(80);
    set_window(127, 31, 0, 63, 1, 0, 1);        // oversize saturates to 80 x 30
    run_items(80);
    set_window(80, 1, 63, 63, 0, 1, 0);
    run_items(80);
    set_window(1, 30, 0, 0, 1, 1, 0);
    run_items(80);
    set_window(80, 30, 42, 21, 0, 0, 1);
    run_items(80);
  endtask

  // Mostly small windows so scrolls and clears stay short; now and then any size.
  task automatic test_random_windows();
    int w;
    int h;
    repeat (10) begin
      idle_on = ($urandom_range(0, 3) != 0);
      w = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 24);
      h = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 8);
      set_window(w, h, $urandom_range(0, 63), $urandom_range(0, 63),
                 $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
      run_items(80);
    end
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_steady_stream();
    idle_on = 1'b0;
    set_window($urandom_range(8, 20), $urandom_range(2, 6), $urandom_range(0, 63),
               $urandom_range(0, 63), 1, $urandom_range(0, 1), 1);
    run_items(250);
  endtask

  initial begin
    reg_width  = WIDTH_RST;
    reg_height = HEIGHT_RST;
    reg_fore   = FORE_RST;
    reg_back   = BACK_RST;
    reg_bold   = BOLD_RST;
    reg_rev    = REV_RST;
    reg_scroll = SCROLL_RST;
    cur_y      = 0;
    cur_x      = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_extreme_sizes();
    test_random_windows();
    test_steady_stream();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
